### rtl/pgs_pkg.sv
`default_nettype none
package pgs_pkg;

  localparam int UNIFORM_W = 24;
  localparam int VALUE_W   = 28;
  localparam int M_W       = 47;
  localparam int NORM_BITS = 30;
  localparam int RATIO_W   = 27;
  localparam int G_W       = 36;
  localparam int P_W       = 63;

  // round(2 ln 2 * 2^24)
  localparam logic [24:0] TWO_LN2_Q24 = 25'd23258160;
  // 46 * 2^30, the scale of m expressed as a log2 offset
  localparam logic [35:0] LOG_OFFSET  = 36'd46 << NORM_BITS;
  localparam logic [35:0] G_ROUND     = 36'd1 << 23;

  localparam logic [28:0] POS_LIMIT = 29'd134217727;
  localparam logic [28:0] NEG_LIMIT = 29'd134217728;

  typedef struct packed {
    logic [M_W-1:0] m;
    logic [M_W-1:0] sqx;
    logic [M_W-1:0] sqy;
    logic           neg_x;
    logic           neg_y;
  } pgs_item_t;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_NORM = 10'b0000000010,
    ST_LOG  = 10'b0000000100,
    ST_GLO  = 10'b0000001000,
    ST_GHI  = 10'b0000010000,
    ST_DIV  = 10'b0000100000,
    ST_PLO  = 10'b0001000000,
    ST_PHI  = 10'b0010000000,
    ST_ROOT = 10'b0100000000,
    ST_EMIT = 10'b1000000000
  } pgs_state_t;

endpackage
`default_nettype wire

### rtl/pgs_if.sv
`default_nettype none
interface pgs_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] first_uniform;
  logic [23:0] second_uniform;
  modport source (output valid, output first_uniform, output second_uniform, input ready);
  modport sink (input valid, input first_uniform, input second_uniform, output ready);
endinterface

interface pgs_out_if;
  logic               valid;
  logic               ready;
  logic signed [27:0] normal_value;
  logic               last_of_pair;
  modport source (output valid, output normal_value, output last_of_pair, input ready);
  modport sink (input valid, input normal_value, input last_of_pair, output ready);
endinterface
`default_nettype wire

### rtl/pgs_front.sv
`default_nettype none
module pgs_front (
  input  wire logic          clk,
  input  wire logic          rst,
  pgs_in_if.sink             uniforms,
  output pgs_pkg::pgs_item_t item,
  output logic               item_valid,
  input  wire logic          item_ready
);

  logic        a_valid;
  logic [46:0] a_sqx;
  logic [46:0] a_sqy;
  logic        a_neg_x;
  logic        a_neg_y;
  logic        b_valid;
  logic        b_keep;
  pgs_pkg::pgs_item_t b_item;

  logic [23:0] ax;
  logic [23:0] ay;
  logic [47:0] sqx_full;
  logic [47:0] sqy_full;
  logic [47:0] m_full;
  logic        adv_a;
  logic        adv_b;

  // Magnitude of u - 2^23; the coordinate is negative when the top bit is clear.
  always_comb begin
    ax = uniforms.first_uniform[23] ? {1'b0, uniforms.first_uniform[22:0]}
                                    : 24'h800000 - {1'b0, uniforms.first_uniform[22:0]};
    ay = uniforms.second_uniform[23] ? {1'b0, uniforms.second_uniform[22:0]}
                                     : 24'h800000 - {1'b0, uniforms.second_uniform[22:0]};
    sqx_full = ax * ax;
    sqy_full = ay * ay;
    m_full   = {1'b0, a_sqx} + {1'b0, a_sqy};
  end

  assign adv_b = !b_valid || !b_keep || item_ready;
  assign adv_a = !a_valid || adv_b;
  assign uniforms.ready = adv_a;
  assign item_valid = b_valid && b_keep;
  assign item = b_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (adv_a) begin
        a_valid <= uniforms.valid;
      end
      if (adv_b) begin
        b_valid <= a_valid;
      end
    end
    if (adv_a && uniforms.valid) begin
      a_sqx   <= sqx_full[46:0];
      a_sqy   <= sqy_full[46:0];
      a_neg_x <= !uniforms.first_uniform[23];
      a_neg_y <= !uniforms.second_uniform[23];
    end
    if (adv_b && a_valid) begin
      b_keep       <= (m_full[47:46] == 2'b00) && (m_full != 48'd0);
      b_item.m     <= m_full[46:0];
      b_item.sqx   <= a_sqx;
      b_item.sqy   <= a_sqy;
      b_item.neg_x <= a_neg_x;
      b_item.neg_y <= a_neg_y;
    end
  end

endmodule
`default_nettype wire

### rtl/pgs_queue.sv
`default_nettype none
module pgs_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  pgs_pkg::pgs_item_t push_item,
  input  wire logic          push_valid,
  output logic               push_ready,
  output pgs_pkg::pgs_item_t pop_item,
  output logic               pop_valid,
  input  wire logic          pop_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pgs_pkg::pgs_item_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

### rtl/pgs_back.sv
`default_nettype none
module pgs_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  pgs_pkg::pgs_item_t item,
  input  wire logic          item_valid,
  output logic               item_ready,
  pgs_out_if.source          deviates
);

  pgs_pkg::pgs_state_t state;
  pgs_pkg::pgs_item_t  cur;
  logic [5:0]  e;
  logic [46:0] norm;
  logic [30:0] z;
  logic [29:0] frac;
  logic [4:0]  cnt;
  logic [42:0] glo;
  logic [35:0] g;
  logic        second;
  logic [47:0] rem;
  logic [26:0] q;
  logic [49:0] plo;
  logic [62:0] v;
  logic [62:0] res;
  logic [62:0] sq_bit;
  logic        out_valid;
  logic signed [27:0] out_value;
  logic        out_last;

  logic [35:0] nl;
  logic [61:0] zz;
  logic [60:0] gsum;
  logic [47:0] rsh;
  logic [62:0] psum;
  logic [62:0] trial;
  logic [33:0] rnd;
  logic [28:0] mag;
  logic [28:0] sat;
  logic        neg;
  logic        out_free;

  always_comb begin
    nl    = pgs_pkg::LOG_OFFSET - {e[5:0], frac};
    zz    = z * z;
    gsum  = {(43'(nl[35:18]) * 43'(pgs_pkg::TWO_LN2_Q24)), 18'd0} + 61'(glo)
            + 61'(pgs_pkg::G_ROUND);
    rsh   = (cnt == 5'd0) ? rem : {rem[46:0], 1'b0};
    psum  = {(49'(g) * 49'(q[26:14])), 14'd0} + 63'(plo);
    trial = res + sq_bit;
    rnd   = res[33:0] + 34'd16;
    mag   = rnd[33:5];
    neg   = second ? cur.neg_x : cur.neg_y;
    if (neg) begin
      sat = (mag > pgs_pkg::NEG_LIMIT) ? pgs_pkg::NEG_LIMIT : mag;
    end else begin
      sat = (mag > pgs_pkg::POS_LIMIT) ? pgs_pkg::POS_LIMIT : mag;
    end
  end

  assign out_free   = !out_valid || deviates.ready;
  assign item_ready = (state == pgs_pkg::ST_IDLE);
  assign deviates.valid        = out_valid;
  assign deviates.normal_value = out_value;
  assign deviates.last_of_pair = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pgs_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == pgs_pkg::ST_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (deviates.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        pgs_pkg::ST_IDLE: begin
          if (item_valid) begin
            state <= pgs_pkg::ST_NORM;
          end
        end
        pgs_pkg::ST_NORM: begin
          if (norm[46]) begin
            state <= pgs_pkg::ST_LOG;
          end
        end
        pgs_pkg::ST_LOG: begin
          if (cnt == 5'd29) begin
            state <= pgs_pkg::ST_GLO;
          end
        end
        pgs_pkg::ST_GLO: state <= pgs_pkg::ST_GHI;
        pgs_pkg::ST_GHI: state <= pgs_pkg::ST_DIV;
        pgs_pkg::ST_DIV: begin
          if (cnt == 5'd26) begin
            state <= pgs_pkg::ST_PLO;
          end
        end
        pgs_pkg::ST_PLO: state <= pgs_pkg::ST_PHI;
        pgs_pkg::ST_PHI: state <= pgs_pkg::ST_ROOT;
        pgs_pkg::ST_ROOT: begin
          if (cnt == 5'd31) begin
            state <= pgs_pkg::ST_EMIT;
          end
        end
        pgs_pkg::ST_EMIT: begin
          if (out_free) begin
            state <= second ? pgs_pkg::ST_IDLE : pgs_pkg::ST_DIV;
          end
        end
        default: state <= pgs_pkg::ST_IDLE;
      endcase
    end

    case (state)
      pgs_pkg::ST_IDLE: begin
        cur  <= item;
        norm <= item.m;
        e    <= 6'd46;
      end
      pgs_pkg::ST_NORM: begin
        if (norm[46]) begin
          z    <= norm[46:16];
          frac <= '0;
          cnt  <= '0;
        end else begin
          norm <= {norm[45:0], 1'b0};
          e    <= e - 1'b1;
        end
      end
      pgs_pkg::ST_LOG: begin
        // Squaring doubles the log; an overflow past 2 yields a fraction bit.
        if (zz[61]) begin
          z    <= zz[61:31];
          frac <= {frac[28:0], 1'b1};
        end else begin
          z    <= zz[60:30];
          frac <= {frac[28:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
      end
      pgs_pkg::ST_GLO: begin
        glo <= nl[17:0] * pgs_pkg::TWO_LN2_Q24;
      end
      pgs_pkg::ST_GHI: begin
        g      <= gsum[59:24];
        second <= 1'b0;
        rem    <= {1'b0, cur.sqy};
        q      <= '0;
        cnt    <= '0;
      end
      pgs_pkg::ST_DIV: begin
        if (rsh >= {1'b0, cur.m}) begin
          rem <= rsh - {1'b0, cur.m};
          q   <= {q[25:0], 1'b1};
        end else begin
          rem <= rsh;
          q   <= {q[25:0], 1'b0};
        end
        cnt <= (cnt == 5'd26) ? 5'd0 : cnt + 1'b1;
      end
      pgs_pkg::ST_PLO: begin
        plo <= g * q[13:0];
      end
      pgs_pkg::ST_PHI: begin
        v      <= psum;
        res    <= '0;
        sq_bit <= 63'd1 << 62;
        cnt    <= '0;
      end
      pgs_pkg::ST_ROOT: begin
        if (v >= trial) begin
          v   <= v - trial;
          res <= {1'b0, res[62:1]} + sq_bit;
        end else begin
          res <= {1'b0, res[62:1]};
        end
        sq_bit <= {2'b00, sq_bit[62:2]};
        cnt    <= cnt + 1'b1;
      end
      pgs_pkg::ST_EMIT: begin
        if (out_free) begin
          out_value <= neg ? -$signed(sat[27:0]) : $signed(sat[27:0]);
          out_last  <= second;
          second    <= 1'b1;
          rem       <= {1'b0, cur.sqx};
          q         <= '0;
          cnt       <= '0;
        end
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/polar_gaussian_sampler_core.sv
`default_nettype none
// Channel    Role   Beat contents
// uniforms   sink   first_uniform, second_uniform (24-bit unsigned fractions)
// deviates   source normal_value (28-bit signed, 2^-23), last_of_pair
//
// The front end squares and sums a pair in two pipeline stages and takes a new
// beat every cycle while the queue has room; rejected pairs are dropped there.
// The back end works on one pair at a time: it takes the pair from the queue,
// normalises it, runs 30 squaring steps for the logarithm and 2 for the scaling,
// then for each deviate 27 division steps, the PLO and PHI multiply steps,
// 32 square-root steps and an output step that waits while the output is stalled.
// Reset is synchronous and clears the pipeline, queue and sequencer.
// A stalled deviates channel holds its register; the back end keeps computing
// the next deviate meanwhile, and the queue lets the front end keep accepting.
module polar_gaussian_sampler_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input wire logic  clk,
  input wire logic  rst,
  pgs_in_if.sink    uniforms,
  pgs_out_if.source deviates
);

  // Accepted pairs pass from the front end to the back end through the queue.
  pgs_pkg::pgs_item_t front_item;
  logic               front_valid;
  logic               front_ready;
  pgs_pkg::pgs_item_t back_item;
  logic               back_valid;
  logic               back_ready;

  pgs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .uniforms   (uniforms),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (front_ready)
  );

  pgs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (front_item),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_item   (back_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  // The y deviate leaves first, then the x deviate marked as last of the pair.
  pgs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (back_item),
    .item_valid (back_valid),
    .item_ready (back_ready),
    .deviates   (deviates)
  );

endmodule
`default_nettype wire
